### rtl/cdq_pkg.sv
// cdq_pkg: shared types and constants for the circular deque
// item structs, operation and status codes, and the cell control struct
// no dependencies
`default_nettype none

package cdq_pkg;

  localparam int unsigned Depth = 16;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } cdq_mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } cdq_status_e;

  typedef struct packed {
    cdq_mode_e          mode;
    logic signed [31:0] push_value;
  } cdq_in_t;

  typedef struct packed {
    cdq_status_e        status;
    logic signed [31:0] popped_value;
  } cdq_out_t;

  // one-hot (or zero) operation strobe, already qualified by accept and status
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_op_t;

endpackage

`default_nettype wire

### rtl/cdq_cell.sv
// cdq_cell: one slot of the deque chain, holding an element and an occupied bit
// shifts toward the rear on a front push and toward the front on a front pop
// depends on cdq_pkg
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire cdq_op_t       op_i,
  input  wire signed [31:0]  push_data_i,
  input  wire                left_occ_i,
  input  wire signed [31:0]  left_data_i,
  input  wire                right_occ_i,
  input  wire signed [31:0]  right_data_i,
  output logic               occ_o,
  output logic signed [31:0] data_o,
  output logic signed [31:0] rear_data_o
);

  logic              occ_q, occ_d;
  logic signed [31:0] data_q, data_d;
  logic              is_rear;
  logic              is_next_free;

  assign is_rear      = occ_q & ~right_occ_i;
  assign is_next_free = ~occ_q & left_occ_i;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    if (op_i.push_front) begin
      occ_d  = left_occ_i;
      data_d = left_data_i;
    end else if (op_i.push_rear) begin
      if (is_next_free) begin
        occ_d  = 1'b1;
        data_d = push_data_i;
      end
    end else if (op_i.pop_front) begin
      occ_d  = right_occ_i;
      data_d = right_data_i;
    end else if (op_i.pop_rear) begin
      if (is_rear) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign occ_o       = occ_q;
  assign data_o      = data_q;
  assign rear_data_o = is_rear ? data_q : '0;

endmodule

`default_nettype wire

### rtl/circular_deque.sv
// circular_deque: double-ended queue built as a chain of element cells
// depends on cdq_pkg and cdq_cell
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries one operation
//   per item: push front, push rear, pop front or pop rear.
//   output channel (out_valid_o / out_stall_i / out_data_o) returns one result
//   per item: status (ok, overflow, empty) and the popped element, zero when
//   nothing was popped.
//   the front element always sits in cell 0 and the rear in the last occupied
//   cell; front operations shift the whole chain by one cell, rear operations
//   touch only the cell at the boundary of the occupied run.
//   the result of an accepted item is registered at the output.
//   throughput: one item per cycle while the receiver takes results; the
//   output register is reloaded in the same cycle its result is taken.
//   a push onto a full deque or a pop from an empty one changes nothing.
//   reset empties the deque and drops any pending result.
//   while the receiver stalls a pending result, the result holds and in_stall_o is raised.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire cdq_in_t in_data_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output cdq_out_t     out_data_o
);

  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  cdq_op_t                   op;
  cdq_status_e               status;
  logic signed [31:0]        popped;
  logic signed [31:0]        rear_value;

  logic                      occ     [Depth];
  logic signed [31:0]        data    [Depth];
  logic signed [31:0]        rear_or [Depth];

  logic                      out_valid_q, out_valid_d;
  cdq_out_t                  out_data_q, out_data_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_full  = occ[Depth-1];
  assign is_empty = ~occ[0];

  always_comb begin
    op     = '0;
    status = ST_OK;
    popped = '0;
    case (in_data_i.mode)
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_OVERFLOW;
        end else begin
          op.push_front = accept;
        end
      end
      MODE_PUSH_REAR: begin
        if (is_full) begin
          status = ST_OVERFLOW;
        end else begin
          op.push_rear = accept;
        end
      end
      MODE_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          op.pop_front = accept;
          popped       = data[0];
        end
      end
      MODE_POP_REAR: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          op.pop_rear = accept;
          popped      = rear_value;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic               l_occ, r_occ;
    logic signed [31:0] l_data, r_data;

    // the ends of the chain see a full cell holding the new item on the left
    // and an empty cell on the right
    if (i == 0) begin : g_first
      assign l_occ  = 1'b1;
      assign l_data = in_data_i.push_value;
    end else begin : g_mid_l
      assign l_occ  = occ[i-1];
      assign l_data = data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign r_occ  = 1'b0;
      assign r_data = '0;
    end else begin : g_mid_r
      assign r_occ  = occ[i+1];
      assign r_data = data[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .push_data_i  (in_data_i.push_value),
      .left_occ_i   (l_occ),
      .left_data_i  (l_data),
      .right_occ_i  (r_occ),
      .right_data_i (r_data),
      .occ_o        (occ[i]),
      .data_o       (data[i]),
      .rear_data_o  (rear_or[i])
    );
  end

  // at most one cell marks itself as the rear, the others give zero
  always_comb begin
    rear_value = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      rear_value = rear_value | rear_or[k];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d             = 1'b1;
      out_data_d.status       = status;
      out_data_d.popped_value = popped;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
